>>> rtl/ktli_pkg.sv
// Shared types and constants for the key table lookup and insert block.
`timescale 1ns / 1ps
`default_nettype none

package ktli_pkg;

	localparam int ENTRIES_DEF = 256;
	localparam int KEY_W       = 64;
	localparam int HANDLE_W    = 32;
	localparam int SIZE_W      = 32;
	localparam int INDEX_W     = 8;

	typedef enum logic [1:0] {
		FUNC_LOOKUP = 2'd0,
		FUNC_INSERT = 2'd1,
		FUNC_FLUSH  = 2'd2
	} ktli_func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_SIZE = 2'd1,
		ST_FULL     = 2'd2
	} ktli_status_t;

	typedef struct packed {
		logic [1:0]          func;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] payload_handle;
		logic [SIZE_W-1:0]   payload_size;
	} ktli_in_t;

	typedef struct packed {
		logic                hit;
		logic [INDEX_W-1:0]  entry_index;
		logic [HANDLE_W-1:0] found_handle;
		logic [SIZE_W-1:0]   found_size;
		logic [1:0]          status;
	} ktli_out_t;

	// Search token handed from cell to cell; the entry index travels beside it.
	typedef struct packed {
		logic                valid;
		logic                found;
		logic                wrote;
		logic [HANDLE_W-1:0] handle;
		logic [SIZE_W-1:0]   size;
	} ktli_token_t;

endpackage

`default_nettype wire

>>> rtl/key_table_lookup_insert_top.sv
// Top level of the key table: request holding, cell chain, result staging and output register.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid, req_stall | req_data (ktli_in_t)
//  rsp     | out       | rsp_valid, rsp_stall | rsp_data (ktli_out_t)
//
// A search token walks the row of ENTRIES cells, one cell per cycle, whatever the operation;
// the result then waits in the pending register until it can move into the output register.
// One transaction is in the chain at a time; the next is taken once the previous result
// has reached the output register, even while that result is still stalled.
// Reset empties the table at once; entry storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module key_table_lookup_insert_top
	import ktli_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire ktli_in_t  req_data,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output ktli_out_t      rsp_data
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	ktli_in_t         req_q;
	logic             busy_q;
	logic             inject_q;
	logic [CNT_W-1:0] fill_q;

	ktli_token_t      tok_head;
	ktli_token_t      tok [ENTRIES+1];
	logic [IDX_W-1:0] tidx [ENTRIES+1];
	logic [ENTRIES:0] tok_vld;

	logic             pend_valid_q;
	ktli_token_t      pend_q;
	logic [IDX_W-1:0] pend_idx_q;

	logic             rsp_valid_q;
	ktli_out_t        rsp_q;
	ktli_out_t        rsp_nxt;

	logic             accept;
	logic             pend_move;
	logic [IDX_W+INDEX_W-1:0] idx_wide;

	assign req_stall = busy_q;
	assign accept    = req_valid && !req_stall;
	assign pend_move = pend_valid_q && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			inject_q <= 1'b0;
		end else begin
			inject_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (pend_move) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		tok_head       = '0;
		tok_head.valid = inject_q;
	end

	assign tok[0]  = tok_head;
	assign tidx[0] = '0;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		ktli_cell #(
			.ENTRIES (ENTRIES),
			.IDX     (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.req     (req_q),
			.fill    (fill_q),
			.tok_in  (tok[g]),
			.idx_in  (tidx[g]),
			.tok_out (tok[g+1]),
			.idx_out (tidx[g+1])
		);
	end

	for (genvar g = 0; g <= ENTRIES; g++) begin : g_vld
		assign tok_vld[g] = tok[g].valid;
	end

	// The table size changes only when the token leaves the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (tok[ENTRIES].valid) begin
				if (req_q.func == FUNC_FLUSH) begin
					fill_q <= '0;
				end else if (tok[ENTRIES].wrote) begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
			if (tok[ENTRIES].valid) begin
				pend_valid_q <= 1'b1;
			end else if (pend_move) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok[ENTRIES].valid) begin
			pend_q     <= tok[ENTRIES];
			pend_idx_q <= tidx[ENTRIES];
		end
	end

	always_comb begin
		idx_wide = {{INDEX_W{1'b0}}, pend_idx_q};
		rsp_nxt  = '0;
		rsp_nxt.status = ST_OK;
		if (req_q.func == FUNC_INSERT && req_q.payload_size == '0) begin
			rsp_nxt.status = ST_BAD_SIZE;
		end else if (req_q.func == FUNC_INSERT && !pend_q.found && !pend_q.wrote) begin
			rsp_nxt.status = ST_FULL;
		end else if (pend_q.found || pend_q.wrote) begin
			rsp_nxt.hit          = pend_q.found;
			rsp_nxt.entry_index  = idx_wide[INDEX_W-1:0];
			rsp_nxt.found_handle = pend_q.handle;
			rsp_nxt.found_size   = pend_q.size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (pend_move) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_move) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Only one transaction is ever in the chain or waiting behind it.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({tok_vld, pend_valid_q}))
		else $error("more than one transaction in the search chain");

	a_exit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tok[ENTRIES].valid |-> busy_q)
		else $error("token left the chain while the block was idle");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(ENTRIES))
		else $error("table fill count beyond capacity");

	a_inject: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> tok_vld[0])
		else $error("accepted transaction not injected into the chain");

endmodule

`default_nettype wire

>>> rtl/ktli_cell.sv
// One table entry with its compare, update and append logic in the search chain.
`timescale 1ns / 1ps
`default_nettype none

module ktli_cell
	import ktli_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int IDX     = 0,
	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ktli_in_t          req,
	input  wire logic [CNT_W-1:0]  fill,
	input  wire ktli_token_t       tok_in,
	input  wire logic [IDX_W-1:0]  idx_in,
	output ktli_token_t            tok_out,
	output logic [IDX_W-1:0]       idx_out
);

	logic [KEY_W-1:0]    key_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [SIZE_W-1:0]   size_q;

	logic        filled;
	logic        live;
	logic        ins_ok;
	logic        is_look;
	logic        hit;
	logic        app;
	ktli_token_t tok_nxt;
	logic [IDX_W-1:0] idx_nxt;
	ktli_token_t tok_q;
	logic        vld_q;
	logic [IDX_W-1:0] idx_q;

	always_comb begin
		filled  = CNT_W'(IDX) < fill;
		live    = tok_in.valid && !tok_in.found && !tok_in.wrote;
		ins_ok  = (req.func == FUNC_INSERT) && (req.payload_size != '0);
		is_look = (req.func == FUNC_LOOKUP);
		hit     = live && filled && (key_q == req.key) && (is_look || ins_ok);
		// The first unfilled entry is reached only when no filled entry matched.
		app     = live && (CNT_W'(IDX) == fill) && ins_ok;

		tok_nxt = tok_in;
		idx_nxt = idx_in;
		if (hit) begin
			tok_nxt.found = 1'b1;
			idx_nxt       = IDX_W'(IDX);
			if (is_look) begin
				tok_nxt.handle = handle_q;
				tok_nxt.size   = size_q;
			end
		end else if (app) begin
			tok_nxt.wrote = 1'b1;
			idx_nxt       = IDX_W'(IDX);
		end
	end

	always_ff @(posedge clk) begin
		if (app) begin
			key_q <= req.key;
		end
		if (app || (hit && !is_look)) begin
			handle_q <= req.payload_handle;
			size_q   <= req.payload_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tok_nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
		idx_q <= idx_nxt;
	end

	// Only the valid flag is reset; the rest of the token is qualified by it.
	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = vld_q;
	end

	assign idx_out = idx_q;

endmodule

`default_nettype wire

>>> verif/key_table_lookup_insert_top_tb.sv
// Self-checking testbench for the key table: lookups, inserts and flushes checked against a shadow table.
`timescale 1ns / 1ps

module key_table_lookup_insert_top_tb;
	import ktli_pkg::*;

	localparam int           TABLE_DEPTH  = ENTRIES_DEF;
	localparam int           RANDOM_ITEMS = 1800;
	localparam int           QUIET_LIMIT  = 5000;
	localparam int           DRAIN_CYCLES = 2 * TABLE_DEPTH;
	localparam logic [1:0]   FUNC_NOP     = 2'd3;

	// Shadow copy of the table: it predicts each result and checks it when it arrives.
	class key_table_shadow;
		logic [KEY_W-1:0]    keys    [TABLE_DEPTH];
		logic [HANDLE_W-1:0] handles [TABLE_DEPTH];
		logic [SIZE_W-1:0]   sizes   [TABLE_DEPTH];
		int unsigned         fill = 0;
		ktli_out_t           awaited_results[$];
		int unsigned         errors = 0;

		function int find_entry(logic [KEY_W-1:0] key);
			for (int i = 0; i < fill; i++)
				if (keys[i] == key)
					return i;
			return -1;
		endfunction

		function void note_request(ktli_in_t req);
			ktli_out_t res;
			int        pos;
			res = '0;
			case (req.func)
			FUNC_LOOKUP: begin
				pos = find_entry(req.key);
				if (pos >= 0) begin
					res.hit          = 1'b1;
					res.entry_index  = pos[INDEX_W-1:0];
					res.found_handle = handles[pos];
					res.found_size   = sizes[pos];
				end
			end
			FUNC_INSERT: begin
				// A zero size is refused before any search, even for a stored key.
				if (req.payload_size == '0) begin
					res.status = ST_BAD_SIZE;
				end else begin
					pos = find_entry(req.key);
					if (pos >= 0) begin
						handles[pos]    = req.payload_handle;
						sizes[pos]      = req.payload_size;
						res.hit         = 1'b1;
						res.entry_index = pos[INDEX_W-1:0];
					end else if (fill < TABLE_DEPTH) begin
						keys[fill]      = req.key;
						handles[fill]   = req.payload_handle;
						sizes[fill]     = req.payload_size;
						res.entry_index = fill[INDEX_W-1:0];
						fill++;
					end else begin
						res.status = ST_FULL;
					end
				end
			end
			FUNC_FLUSH: fill = 0;
			default: ;
			endcase
			awaited_results.push_back(res);
		endfunction

		function void compare_field(string field, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(ktli_out_t got);
			ktli_out_t want;
			if (awaited_results.size() == 0) begin
				$display("%0t: result with nothing outstanding, expected none, actual %h",
					$time, got);
				errors++;
			end else begin
				want = awaited_results.pop_front();
				compare_field("hit", 64'(want.hit), 64'(got.hit));
				compare_field("entry_index", 64'(want.entry_index), 64'(got.entry_index));
				compare_field("found_handle", 64'(want.found_handle), 64'(got.found_handle));
				compare_field("found_size", 64'(want.found_size), 64'(got.found_size));
				compare_field("status", 64'(want.status), 64'(got.status));
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	ktli_in_t  req_data;
	logic      rsp_valid;
	logic      rsp_stall;
	ktli_out_t rsp_data;

	key_table_shadow shadow;
	int unsigned     issued;
	int unsigned     quiet_cycles = 0;

	key_table_lookup_insert_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic ktli_in_t make_request(logic [1:0] func, logic [KEY_W-1:0] key,
			logic [HANDLE_W-1:0] handle, logic [SIZE_W-1:0] size);
		ktli_in_t req;
		req.func           = func;
		req.key            = key;
		req.payload_handle = handle;
		req.payload_size   = size;
		return req;
	endfunction

	function automatic int sender_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 30);
		return $urandom_range(100, 400);
	endfunction

	function automatic logic [KEY_W-1:0] fresh_key();
		// Small keys now and then, so that fresh inserts sometimes land on a stored key.
		if ($urandom_range(0, 7) == 0)
			return 64'($urandom_range(0, 15));
		return {$urandom, $urandom};
	endfunction

	function automatic logic [KEY_W-1:0] known_key();
		if (shadow.fill == 0)
			return fresh_key();
		return shadow.keys[$urandom_range(0, shadow.fill - 1)];
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 19))
		0: return '1;
		1: return 32'd1;
		default: return $urandom;
		endcase
	endfunction

	function automatic ktli_in_t pick_request(bit filling);
		ktli_in_t    req;
		int unsigned roll;
		req  = make_request(FUNC_INSERT, fresh_key(), $urandom, pick_size());
		roll = $urandom_range(0, 99);
		if (filling) begin
			if (roll < 8) begin
				req.func = FUNC_LOOKUP;
				req.key  = known_key();
			end else if (roll < 12) begin
				req.key = known_key();
			end else if (roll < 14) begin
				req.key          = known_key();
				req.payload_size = '0;
			end
		end else if (roll < 30) begin
			req.func = FUNC_LOOKUP;
			req.key  = known_key();
		end else if (roll < 40) begin
			// Near miss: one key bit away from a stored key.
			req.func = FUNC_LOOKUP;
			req.key  = known_key() ^ (64'd1 << $urandom_range(0, KEY_W - 1));
		end else if (roll < 65) begin
		end else if (roll < 82) begin
			req.key = known_key();
		end else if (roll < 90) begin
			req.key          = roll[0] ? known_key() : fresh_key();
			req.payload_size = '0;
		end else if (roll < 94) begin
			req.func = FUNC_NOP;
		end else begin
			req.func = FUNC_FLUSH;
		end
		return req;
	endfunction

	// Presents one transaction after a random gap and holds it until it is taken.
	task automatic send_request(ktli_in_t req);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= req;
		do @(posedge clk); while (req_stall !== 1'b0);
		shadow.note_request(req);
		issued++;
	endtask

	task automatic wait_for_results();
		req_valid <= 1'b0;
		while (shadow.awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// Receiver stalls: short bursts mostly, a few long ones, and long clear stretches.
	initial begin
		int unsigned roll;
		int unsigned span;
		rsp_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			roll = $urandom_range(0, 99);
			if (roll < 35) begin
				rsp_stall <= 1'b0;
				span = $urandom_range(1, 40);
			end else if (roll < 40) begin
				rsp_stall <= 1'b0;
				span = $urandom_range(200, 800);
			end else if (roll < 85) begin
				rsp_stall <= 1'b1;
				span = $urandom_range(1, 3);
			end else if (roll < 96) begin
				rsp_stall <= 1'b1;
				span = $urandom_range(4, 20);
			end else begin
				rsp_stall <= 1'b1;
				span = $urandom_range(100, 300);
			end
			repeat (span) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				shadow.check_result(rsp_data);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
				$display("key_table_lookup_insert_top_tb NOT OK");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int episode;
		shadow = new();
		issued = 0;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req_data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(make_request(FUNC_LOOKUP, '0, '0, '0));
		send_request(make_request(FUNC_INSERT, '0, '0, '1));
		send_request(make_request(FUNC_INSERT, '1, '1, 32'd1));
		send_request(make_request(FUNC_LOOKUP, '0, '1, '1));
		send_request(make_request(FUNC_LOOKUP, '1, '0, '0));
		send_request(make_request(FUNC_LOOKUP, 64'd1, '0, '0));
		// Zero size is refused whether or not the key is stored.
		send_request(make_request(FUNC_INSERT, '0, 32'h1234_5678, '0));
		send_request(make_request(FUNC_INSERT, 64'h8000_0000_0000_0000, '1, '0));
		send_request(make_request(FUNC_LOOKUP, 64'h8000_0000_0000_0000, '0, '0));
		send_request(make_request(FUNC_LOOKUP, '0, '0, '0));
		send_request(make_request(FUNC_INSERT, '1, 32'hDEAD_BEEF, 32'h0000_0100));
		send_request(make_request(FUNC_LOOKUP, '1, '0, '0));
		send_request(make_request(FUNC_NOP, '1, '1, '1));
		send_request(make_request(FUNC_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0));
		send_request(make_request(FUNC_FLUSH, '1, '1, '1));
		send_request(make_request(FUNC_LOOKUP, '1, '0, '0));
		send_request(make_request(FUNC_INSERT, 64'hA5A5_A5A5_A5A5_A5A5, 32'h5A5A_5A5A,
			32'hA5A5_A5A5));
		send_request(make_request(FUNC_INSERT, 64'h5A5A_5A5A_5A5A_5A5A, 32'hA5A5_A5A5,
			32'h5A5A_5A5A));
		send_request(make_request(FUNC_LOOKUP, 64'h5A5A_5A5A_5A5A_5A5A, '0, '0));
		send_request(make_request(FUNC_FLUSH, '0, '0, '0));

		issued  = 0;
		episode = 0;
		while (issued < RANDOM_ITEMS) begin
			if (episode % 5 == 1) begin
				// Fill the table to its last entry, then keep working on it with random requests from full.
				send_request(make_request(FUNC_FLUSH, '0, '0, '0));
				while (shadow.fill < TABLE_DEPTH)
					send_request(pick_request(1'b1));
				repeat ($urandom_range(20, 40))
					send_request(pick_request(1'b0));
				send_request(make_request(FUNC_LOOKUP, shadow.keys[TABLE_DEPTH - 1], '0, '0));
				send_request(make_request(FUNC_FLUSH, '0, '0, '0));
				if (episode == 1)
					wait_for_results();
			end else begin
				if ($urandom_range(0, 1) == 0)
					send_request(make_request(FUNC_FLUSH, '0, '0, '0));
				repeat ($urandom_range(20, 150))
					send_request(pick_request(1'b0));
			end
			episode++;
		end

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (shadow.errors == 0)
			$display("key_table_lookup_insert_top_tb OK");
		else
			$display("key_table_lookup_insert_top_tb NOT OK");
		$finish;
	end

endmodule

>>> filelist.f
rtl/ktli_pkg.sv
rtl/ktli_cell.sv
rtl/key_table_lookup_insert_top.sv
verif/key_table_lookup_insert_top_tb.sv
